>>> sv/http_header_skip_body_capture_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the HTTP header skip / body capture block
// Compiled to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HTTP_HEADER_SKIP_BODY_CAPTURE_DEFINES_SVH
`define HTTP_HEADER_SKIP_BODY_CAPTURE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define HHSB_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define HHSB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define HHSB_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define HHSB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> sv/hhsb_pkg.sv
// ----------------------------------------------------------------------------
// hhsb_pkg
// Types, constants and helpers shared by the header skip / body capture block.
// ----------------------------------------------------------------------------
`default_nettype none

package hhsb_pkg;

	localparam int BODY_BYTES     = 4736;
	localparam int POS_W          = 13;
	localparam int LINE_CAPACITY  = 128;
	localparam int LINE_KEEP      = LINE_CAPACITY - 1;
	localparam int LINE_LEN_W     = 7;
	localparam int VALUE_CAPACITY = 64;
	localparam int VALUE_KEEP     = VALUE_CAPACITY - 1;
	localparam int VAL_ADDR_W     = 6;
	localparam int PREFIX_LEN     = 13;
	localparam int CMD_FIFO_DEPTH = 4;
	localparam int CMD_PTR_W      = 2;
	localparam int CMD_CNT_W      = 3;

	localparam logic [7:0] BYTE_CR = 8'h0D;
	localparam logic [7:0] BYTE_LF = 8'h0A;

	typedef enum logic [2:0] {
		KIND_NONE       = 3'd0,
		KIND_BODY       = 3'd1,
		KIND_SYNC_CHAR  = 3'd2,
		KIND_SYNC_EMPTY = 3'd3,
		KIND_HDRS_DONE  = 3'd4,
		KIND_COMPLETED  = 3'd5,
		KIND_FAILED     = 3'd6
	} kind_t;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       payload;
		logic [POS_W-1:0] position;
		logic             last;
	} result_t;

	typedef enum logic {
		CMD_SINGLE = 1'b0,
		CMD_RUN    = 1'b1
	} cmd_op_t;

	// one queued job for the back end
	typedef struct packed {
		cmd_op_t               op;
		kind_t                 kind;
		logic [7:0]            payload;
		logic [POS_W-1:0]      position;
		logic [VAL_ADDR_W-1:0] run_len;
		logic                  trail;
		kind_t                 trail_kind;
	} cmd_t;

	typedef struct packed {
		logic                  en;
		logic [VAL_ADDR_W-1:0] addr;
		logic [7:0]            data;
	} mem_wr_t;

	typedef struct packed {
		logic run_pending;
	} front_stat_t;

	// "X-Sync-Time: "
	function automatic logic [7:0] prefix_char(input logic [3:0] idx);
		logic [7:0] ch;
		unique case (idx)
			4'd0:    ch = 8'h58;
			4'd1:    ch = 8'h2D;
			4'd2:    ch = 8'h53;
			4'd3:    ch = 8'h79;
			4'd4:    ch = 8'h6E;
			4'd5:    ch = 8'h63;
			4'd6:    ch = 8'h2D;
			4'd7:    ch = 8'h54;
			4'd8:    ch = 8'h69;
			4'd9:    ch = 8'h6D;
			4'd10:   ch = 8'h65;
			4'd11:   ch = 8'h3A;
			4'd12:   ch = 8'h20;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

>>> sv/http_header_skip_body_capture.sv
// ----------------------------------------------------------------------------
// http_header_skip_body_capture
// HTTP response splitter: skips headers, captures the X-Sync-Time value and
// streams body bytes with their offsets.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: one beat per received octet (func 0) or a close event
//   (func 1). result channel: result beats, last marks the final beat caused
//   by one input beat; an input beat may cause none.
//   With an empty queue the job for an input beat is written into the queue,
//   then its result into the output register. Body and header bytes sustain
//   one beat per cycle while item_stall is low; a body byte that fills the
//   buffer takes two output beats (byte, then done). A header line carrying
//   X-Sync-Time holds item_stall high while its value is read out of the
//   63-entry value store, one character per cycle unless the receiver stalls.
//   A four-entry job queue separates intake from output: when the receiver
//   stalls, the queue fills and item_stall rises; nothing is dropped.
//   Reset returns to the header phase with all counters cleared. After
//   completion or failure every input beat is taken and ignored until reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "http_header_skip_body_capture_defines.svh"

module http_header_skip_body_capture (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  item_valid,
	output logic                 item_stall,
	input  hhsb_pkg::item_t      item,
	output logic                 result_valid,
	input  wire                  result_stall,
	output hhsb_pkg::result_t    result
);
	import hhsb_pkg::*;

	logic        cmd_push;
	cmd_t        cmd;
	cmd_t        head;
	logic        fifo_empty;
	logic        fifo_full;
	logic        cmd_pop;
	mem_wr_t     mem_wr;
	logic        run_done;
	front_stat_t front_stat;
	logic        close_take;

	assign close_take = item_valid && !item_stall && item.func;

	hhsb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.fifo_full  (fifo_full),
		.cmd_push   (cmd_push),
		.cmd        (cmd),
		.mem_wr     (mem_wr),
		.run_done   (run_done),
		.stat       (front_stat)
	);

	hhsb_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (cmd),
		.pop      (cmd_pop),
		.head     (head),
		.empty    (fifo_empty),
		.full     (fifo_full)
	);

	hhsb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (fifo_empty),
		.pop          (cmd_pop),
		.mem_wr       (mem_wr),
		.run_done     (run_done),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	`HHSB_ASSERT_IMPLIES(a_pending_blocks, clk, arst_n, front_stat.run_pending, item_stall)
	`HHSB_ASSERT_IMPLIES(a_no_push_full, clk, arst_n, cmd_push, !fifo_full)
	`HHSB_ASSERT_IMPLIES(a_done_has_run, clk, arst_n, run_done, front_stat.run_pending)
	`HHSB_ASSERT_NEXT(a_close_no_run, clk, arst_n, close_take, !front_stat.run_pending)

endmodule

`default_nettype wire

>>> sv/hhsb_front.sv
// ----------------------------------------------------------------------------
// hhsb_front
// Accepts bytes, tracks header/body phase, line and prefix match, stores value
// characters and queues output jobs for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hhsb_front (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      item_valid,
	output logic                     item_stall,
	input  hhsb_pkg::item_t          item,
	input  wire                      fifo_full,
	output logic                     cmd_push,
	output hhsb_pkg::cmd_t           cmd,
	output hhsb_pkg::mem_wr_t        mem_wr,
	input  wire                      run_done,
	output hhsb_pkg::front_stat_t    stat
);
	import hhsb_pkg::*;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_BODY   = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	phase_t                phase_q;
	logic [1:0]            end_idx_q;
	logic [LINE_LEN_W-1:0] line_len_q;
	logic                  match_q;
	logic [POS_W-1:0]      body_count_q;
	logic                  run_pending_q;

	logic                  accept;
	logic                  is_cr;
	logic                  is_lf;
	logic                  keep;
	logic                  in_prefix;
	logic                  prefix_ok;
	logic [LINE_LEN_W-1:0] value_off;
	logic                  emit_run;
	logic                  hdrs_done;
	logic [POS_W-1:0]      body_next;
	logic                  active;

	assign item_stall      = fifo_full || run_pending_q;
	assign accept          = item_valid && !item_stall;
	assign stat.run_pending = run_pending_q;

	assign active    = (phase_q == PH_HEADER) || (phase_q == PH_BODY);
	assign is_cr     = item.data_byte == BYTE_CR;
	assign is_lf     = item.data_byte == BYTE_LF;
	assign keep      = !is_cr && !is_lf && (line_len_q != LINE_LEN_W'(LINE_KEEP));
	assign in_prefix = line_len_q < LINE_LEN_W'(PREFIX_LEN);
	assign prefix_ok = item.data_byte == prefix_char(line_len_q[3:0]);
	assign value_off = line_len_q - LINE_LEN_W'(PREFIX_LEN);
	assign emit_run  = is_lf && !in_prefix && match_q;
	assign hdrs_done = (end_idx_q == 2'd3) && is_lf;
	assign body_next = body_count_q + POS_W'(1);

	always_comb begin
		cmd_push   = 1'b0;
		cmd        = '0;
		cmd.op     = CMD_SINGLE;
		cmd.kind   = KIND_NONE;
		cmd.trail_kind = KIND_NONE;
		mem_wr     = '0;
		mem_wr.addr = value_off[VAL_ADDR_W-1:0];
		mem_wr.data = item.data_byte;
		if (accept && active) begin
			if (item.func) begin
				cmd_push = 1'b1;
				cmd.kind = (body_count_q == POS_W'(BODY_BYTES)) ? KIND_COMPLETED : KIND_FAILED;
			end else if (phase_q == PH_BODY) begin
				cmd_push     = 1'b1;
				cmd.kind     = KIND_BODY;
				cmd.payload  = item.data_byte;
				cmd.position = body_count_q;
				cmd.trail    = body_next == POS_W'(BODY_BYTES);
				cmd.trail_kind = KIND_COMPLETED;
			end else begin
				mem_wr.en = keep && !in_prefix && (value_off < LINE_LEN_W'(VALUE_KEEP));
				if (emit_run) begin
					cmd_push   = 1'b1;
					cmd.op     = CMD_RUN;
					cmd.kind   = KIND_SYNC_CHAR;
					cmd.run_len = (value_off > LINE_LEN_W'(VALUE_KEEP)) ?
						VAL_ADDR_W'(VALUE_KEEP) : value_off[VAL_ADDR_W-1:0];
					cmd.trail  = hdrs_done;
					cmd.trail_kind = KIND_HDRS_DONE;
				end else if (hdrs_done) begin
					cmd_push = 1'b1;
					cmd.kind = KIND_HDRS_DONE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HEADER;
			end_idx_q     <= 2'd0;
			line_len_q    <= '0;
			match_q       <= 1'b1;
			body_count_q  <= '0;
			run_pending_q <= 1'b0;
		end else begin
			if (run_done) begin
				run_pending_q <= 1'b0;
			end
			if (accept) begin
				unique case (phase_q)
					PH_HEADER: begin
						if (item.func) begin
							phase_q <= PH_DONE;
						end else begin
							if (keep) begin
								if (in_prefix && !prefix_ok) begin
									match_q <= 1'b0;
								end
								line_len_q <= line_len_q + LINE_LEN_W'(1);
							end else if (is_lf) begin
								line_len_q <= '0;
								match_q    <= 1'b1;
								if (emit_run) begin
									run_pending_q <= 1'b1;
								end
							end
							// CR LF CR LF tracker, any out-of-sequence CR restarts it
							if (end_idx_q == 2'd0 && is_cr) begin
								end_idx_q <= 2'd1;
							end else if (end_idx_q == 2'd1 && is_lf) begin
								end_idx_q <= 2'd2;
							end else if (end_idx_q == 2'd2 && is_cr) begin
								end_idx_q <= 2'd3;
							end else if (hdrs_done) begin
								end_idx_q <= 2'd0;
								phase_q   <= PH_BODY;
							end else begin
								end_idx_q <= is_cr ? 2'd1 : 2'd0;
							end
						end
					end
					PH_BODY: begin
						if (item.func) begin
							phase_q <= PH_DONE;
						end else begin
							body_count_q <= body_next;
							if (body_next == POS_W'(BODY_BYTES)) begin
								phase_q <= PH_DONE;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/hhsb_cmd_fifo.sv
// ----------------------------------------------------------------------------
// hhsb_cmd_fifo
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hhsb_cmd_fifo (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  hhsb_pkg::cmd_t    push_cmd,
	input  wire               pop,
	output hhsb_pkg::cmd_t    head,
	output logic              empty,
	output logic              full
);
	import hhsb_pkg::*;

	cmd_t                 entries_q [CMD_FIFO_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_CNT_W-1:0] count_q;

	assign empty = count_q == '0;
	assign full  = count_q == CMD_CNT_W'(CMD_FIFO_DEPTH);
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + CMD_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + CMD_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CMD_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CMD_CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/hhsb_back.sv
// ----------------------------------------------------------------------------
// hhsb_back
// Runs queued jobs: single result beats, or a sync-time value run read out of
// the value store, and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hhsb_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  hhsb_pkg::cmd_t       head,
	input  wire                  empty,
	output logic                 pop,
	input  hhsb_pkg::mem_wr_t    mem_wr,
	output logic                 run_done,
	output logic                 result_valid,
	input  wire                  result_stall,
	output hhsb_pkg::result_t    result
);
	import hhsb_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_NEXT,
		ST_LASTCH,
		ST_EMPTY,
		ST_TRAIL
	} state_t;

	logic [7:0]            val_mem [VALUE_KEEP];
	logic [7:0]            rdata_q;
	logic                  rd_en;
	logic [VAL_ADDR_W-1:0] rd_addr;

	state_t                state_q;
	cmd_t                  cmd_q;
	logic [VAL_ADDR_W-1:0] idx_q;
	logic [7:0]            cur_q;
	logic [VAL_ADDR_W-1:0] cur_pos_q;
	logic                  out_valid_q;
	result_t               out_q;
	logic                  run_done_q;

	logic                  can_load;
	logic                  more_addr;
	logic                  rd_nonzero;
	logic [VAL_ADDR_W:0]   idx_inc;

	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign run_done     = run_done_q;

	assign can_load   = !out_valid_q || !result_stall;
	assign idx_inc    = {1'b0, idx_q} + (VAL_ADDR_W+1)'(1);
	assign more_addr  = idx_inc < {1'b0, cmd_q.run_len};
	assign rd_nonzero = rdata_q != 8'h00;

	assign pop = (state_q == ST_IDLE) && !empty && ((head.op == CMD_RUN) || can_load);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_inc[VAL_ADDR_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				rd_en   = pop && (head.op == CMD_RUN) && (head.run_len != '0);
				rd_addr = '0;
			end
			ST_FIRST: rd_en = rd_nonzero && more_addr;
			ST_NEXT:  rd_en = can_load && rd_nonzero && more_addr;
			default:  rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			val_mem[mem_wr.addr] <= mem_wr.data;
		end
		if (rd_en) begin
			rdata_q <= val_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			cur_q       <= '0;
			cur_pos_q   <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			run_done_q  <= 1'b0;
		end else begin
			run_done_q <= 1'b0;
			if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (head.op == CMD_SINGLE) begin
							out_valid_q    <= 1'b1;
							out_q.kind     <= head.kind;
							out_q.payload  <= head.payload;
							out_q.position <= head.position;
							out_q.last     <= !head.trail;
							if (head.trail) begin
								state_q <= ST_TRAIL;
							end
						end else if (head.run_len == '0) begin
							state_q <= ST_EMPTY;
						end else begin
							idx_q   <= '0;
							state_q <= ST_FIRST;
						end
					end
				end
				ST_FIRST: begin
					if (!rd_nonzero) begin
						state_q <= ST_EMPTY;
					end else begin
						cur_q     <= rdata_q;
						cur_pos_q <= '0;
						if (more_addr) begin
							idx_q   <= idx_inc[VAL_ADDR_W-1:0];
							state_q <= ST_NEXT;
						end else begin
							state_q <= ST_LASTCH;
						end
					end
				end
				ST_NEXT: begin
					// rdata holds the char after cur; a zero ends the value
					if (can_load) begin
						out_valid_q    <= 1'b1;
						out_q.kind     <= KIND_SYNC_CHAR;
						out_q.payload  <= cur_q;
						out_q.position <= POS_W'(cur_pos_q);
						out_q.last     <= !rd_nonzero && !cmd_q.trail;
						if (rd_nonzero) begin
							cur_q     <= rdata_q;
							cur_pos_q <= idx_q;
							if (more_addr) begin
								idx_q <= idx_inc[VAL_ADDR_W-1:0];
							end else begin
								state_q <= ST_LASTCH;
							end
						end else if (cmd_q.trail) begin
							state_q <= ST_TRAIL;
						end else begin
							state_q    <= ST_IDLE;
							run_done_q <= 1'b1;
						end
					end
				end
				ST_LASTCH: begin
					if (can_load) begin
						out_valid_q    <= 1'b1;
						out_q.kind     <= KIND_SYNC_CHAR;
						out_q.payload  <= cur_q;
						out_q.position <= POS_W'(cur_pos_q);
						out_q.last     <= !cmd_q.trail;
						if (cmd_q.trail) begin
							state_q <= ST_TRAIL;
						end else begin
							state_q    <= ST_IDLE;
							run_done_q <= 1'b1;
						end
					end
				end
				ST_EMPTY: begin
					if (can_load) begin
						out_valid_q    <= 1'b1;
						out_q.kind     <= KIND_SYNC_EMPTY;
						out_q.payload  <= '0;
						out_q.position <= '0;
						out_q.last     <= !cmd_q.trail;
						if (cmd_q.trail) begin
							state_q <= ST_TRAIL;
						end else begin
							state_q    <= ST_IDLE;
							run_done_q <= 1'b1;
						end
					end
				end
				ST_TRAIL: begin
					if (can_load) begin
						out_valid_q    <= 1'b1;
						out_q.kind     <= cmd_q.trail_kind;
						out_q.payload  <= '0;
						out_q.position <= '0;
						out_q.last     <= 1'b1;
						state_q        <= ST_IDLE;
						run_done_q     <= cmd_q.op == CMD_RUN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
